// ===== hdl/hcbp_pkg.sv =====
// Shared types and constants of the Huffman code bit packer.
// Used by hcbp_code_table, hcbp_packer and huffman_code_bit_packer; depends on nothing.
package hcbp_pkg;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int SYM_W      = 8;
   localparam int CODE_W     = 32;
   localparam int LEN_IN_W   = 6;
   localparam int BYTE_W     = 8;
   localparam int FILL_W     = 3;

   // parameter defaults
   localparam int DEF_MAX_CODE_LEN = 32;
   localparam int DEF_SYMBOLS      = 256;

   // request op codes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_PACK,
      ST_FLUSH
   } state_type;

   // sequencer to packer
   typedef struct packed {
      logic load;
      logic flush;
   } pack_ctrl_type;

   // packer to sequencer
   typedef struct packed {
      logic rem_zero;
      logic flush_ack;
   } pack_status_type;

endpackage

// ===== hdl/hcbp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/hcbp_code_table.sv =====
// Code table: code word and length per symbol in one RAM, plus per-entry
// valid bits so an unloaded symbol reads as length zero. Depends on hcbp_pkg, hcbp_ram.
module hcbp_code_table #(
   parameter int SYMBOLS = hcbp_pkg::DEF_SYMBOLS,
   parameter int CAP     = hcbp_pkg::DEF_MAX_CODE_LEN,
   parameter int LEN_W   = $clog2(hcbp_pkg::DEF_MAX_CODE_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(SYMBOLS)-1:0]    wr_addr,
   input  logic [hcbp_pkg::CODE_W-1:0]   wr_code,
   input  logic [hcbp_pkg::LEN_IN_W-1:0] wr_len,
   input  logic                          rd_en,
   input  logic [$clog2(SYMBOLS)-1:0]    rd_addr,
   output logic [hcbp_pkg::CODE_W-1:0]   rd_code,
   output logic [LEN_W-1:0]              rd_len
);

   localparam int ENTRY_W = hcbp_pkg::CODE_W + LEN_W;

   logic [SYMBOLS-1:0] valid_ff;
   logic [SYMBOLS-1:0] valid_in;
   logic               rd_valid_ff;
   logic [LEN_W-1:0]   len_sat;
   logic [ENTRY_W-1:0] rd_entry;

   // saturate an overlong length on the way in
   always_comb begin
      if (wr_len > hcbp_pkg::LEN_IN_W'(CAP)) begin
         len_sat = LEN_W'(CAP);
      end else begin
         len_sat = LEN_W'(wr_len);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_code, len_sat}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign rd_code = rd_entry[ENTRY_W-1 -: hcbp_pkg::CODE_W];
   assign rd_len  = rd_valid_ff ? rd_entry[LEN_W-1:0] : '0;

endmodule

// ===== hdl/hcbp_packer.sv =====
// Byte-digit packer: left-aligned code shift register, byte buffer and
// output register. Depends on hcbp_pkg.
module hcbp_packer #(
   parameter int LEN_W = $clog2(hcbp_pkg::DEF_MAX_CODE_LEN + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hcbp_pkg::pack_ctrl_type        ctrl,
   input  logic [hcbp_pkg::CODE_W-1:0]    code_in,
   input  logic [LEN_W-1:0]               len_in,
   output hcbp_pkg::pack_status_type      status,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hcbp_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                           rsp_last
);

   localparam int CODE_W = hcbp_pkg::CODE_W;
   localparam int BYTE_W = hcbp_pkg::BYTE_W;
   localparam int FILL_W = hcbp_pkg::FILL_W;
   localparam int SHA_W  = $clog2(CODE_W + 1);
   localparam int CMP_W  = LEN_W + 1;
   localparam int AV_W   = FILL_W + 1;

   logic [CODE_W-1:0] sh_ff, sh_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [BYTE_W-1:0] buf_ff, buf_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              ovalid_ff, ovalid_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic              olast_ff, olast_in;

   logic              out_free;
   logic [AV_W-1:0]   avail;
   logic [BYTE_W-1:0] merged;
   logic [CMP_W-1:0]  rem_x, avail_x, after;
   logic              rem_ge;
   logic [SHA_W-1:0]  align_amt;

   assign out_free  = !ovalid_ff || !rsp_stall;
   assign avail     = AV_W'(BYTE_W) - {1'b0, fill_ff};
   assign merged    = buf_ff | (sh_ff[CODE_W-1 -: BYTE_W] >> fill_ff);
   assign rem_x     = {1'b0, rem_ff};
   assign avail_x   = CMP_W'(avail);
   assign rem_ge    = rem_x >= avail_x;
   assign after     = rem_x - avail_x;
   assign align_amt = SHA_W'(CODE_W) - SHA_W'(len_in);

   always_comb begin
      sh_in     = sh_ff;
      rem_in    = rem_ff;
      buf_in    = buf_ff;
      fill_in   = fill_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      if (ctrl.load) begin
         // first code bit to the top of the shift register
         sh_in  = code_in << align_amt;
         rem_in = len_in;
      end else if (rem_ff != '0) begin
         if (rem_ge) begin
            // digit fills the byte: emit once the output slot frees up
            if (out_free) begin
               ovalid_in = 1'b1;
               obyte_in  = merged;
               olast_in  = after < CMP_W'(BYTE_W);
               buf_in    = '0;
               fill_in   = '0;
               sh_in     = sh_ff << avail;
               rem_in    = after[LEN_W-1:0];
            end
         end else begin
            buf_in  = merged;
            fill_in = fill_ff + rem_ff[FILL_W-1:0];
            rem_in  = '0;
         end
      end else if (ctrl.flush && fill_ff != '0 && out_free) begin
         ovalid_in = 1'b1;
         obyte_in  = buf_ff;
         olast_in  = 1'b1;
         buf_in    = '0;
         fill_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         buf_ff    <= '0;
         fill_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         rem_ff    <= rem_in;
         buf_ff    <= buf_in;
         fill_ff   <= fill_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff    <= sh_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   assign status.rem_zero  = rem_ff == '0;
   assign status.flush_ack = ctrl.flush && (fill_ff == '0 || out_free);

   assign rsp_valid    = ovalid_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_last     = olast_ff;

endmodule

// ===== hdl/huffman_code_bit_packer.sv =====
// A load is written to the table from the accepted request; an encode reads the table,
// loads the packer in LOOKUP and leaves words through the output register in PACK.
// Requests are taken only in idle; the packer moves one digit per cycle unless output stalls.
// Reset: synchronous, clears sequencer, bit buffer, fill count and table valid bits
// (unloaded symbols read length zero at once, no clearing pass).
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
   parameter int SYMBOLS      = hcbp_pkg::DEF_SYMBOLS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hcbp_pkg::OP_W-1:0]       req_op,
   input  logic [hcbp_pkg::SYM_W-1:0]      req_symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]     req_code_word,
   input  logic [hcbp_pkg::LEN_IN_W-1:0]   req_code_length,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hcbp_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_last
);

   // longest code kept in the table
   localparam int CAP   = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                            : hcbp_pkg::CODE_W;
   localparam int LEN_W = $clog2(CAP + 1);
   localparam int AW    = $clog2(SYMBOLS);
   localparam int SX_W  = hcbp_pkg::SYM_W + 1;

   hcbp_pkg::state_type       state_ff, state_in;
   hcbp_pkg::pack_ctrl_type   ctrl;
   hcbp_pkg::pack_status_type status;

   logic                          accept;
   logic                          in_range;
   logic                          tbl_wr;
   logic                          tbl_rd;
   logic [hcbp_pkg::CODE_W-1:0]   tbl_code;
   logic [LEN_W-1:0]              tbl_len;

   // one request word is taken only from idle
   assign accept   = req_valid && !req_stall;
   // symbols at or above the table depth are dropped
   assign in_range = {1'b0, req_symbol} < SX_W'(SYMBOLS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == hcbp_pkg::OP_ENCODE && in_range) begin
                  state_in = hcbp_pkg::ST_LOOKUP;
               end else if (req_op == hcbp_pkg::OP_FLUSH) begin
                  state_in = hcbp_pkg::ST_FLUSH;
               end
            end
         end
         // table read data lands here and goes into the packer
         hcbp_pkg::ST_LOOKUP: begin
            state_in = hcbp_pkg::ST_PACK;
         end
         // hold until every code bit sits in a word or in the bit buffer
         hcbp_pkg::ST_PACK: begin
            if (status.rem_zero) begin
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         // hold until the partial byte is out (or there was none)
         hcbp_pkg::ST_FLUSH: begin
            if (status.flush_ack) begin
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hcbp_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall  = 1'b1;
      ctrl.load  = 1'b0;
      ctrl.flush = 1'b0;
      case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         hcbp_pkg::ST_LOOKUP: begin
            ctrl.load = 1'b1;
         end
         hcbp_pkg::ST_PACK: begin
            req_stall = 1'b1;
         end
         hcbp_pkg::ST_FLUSH: begin
            ctrl.flush = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // loads write code and length together; encodes read both
   assign tbl_wr = accept && req_op == hcbp_pkg::OP_LOAD && in_range;
   assign tbl_rd = accept && req_op == hcbp_pkg::OP_ENCODE && in_range;

   hcbp_code_table #(
      .SYMBOLS (SYMBOLS),
      .CAP     (CAP),
      .LEN_W   (LEN_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr),
      .wr_addr (req_symbol[AW-1:0]),
      .wr_code (req_code_word),
      .wr_len  (req_code_length),
      .rd_en   (tbl_rd),
      .rd_addr (req_symbol[AW-1:0]),
      .rd_code (tbl_code),
      .rd_len  (tbl_len)
   );

   // advance up to one byte of code bits per cycle into the output word or bit buffer, holding while output stalls
   hcbp_packer #(
      .LEN_W (LEN_W)
   ) u_packer (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .code_in      (tbl_code),
      .len_in       (tbl_len),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   // a new response word only appears while packing or flushing
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         ($past(state_ff) == hcbp_pkg::ST_PACK || $past(state_ff) == hcbp_pkg::ST_FLUSH))
   else $error("response word raised outside pack or flush");

   // no code bits may be left over once the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == hcbp_pkg::ST_IDLE |-> status.rem_zero)
   else $error("packer holds code bits while idle");

   // an acknowledged flush returns the sequencer to idle, and a stalled response word stays stable
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hcbp_pkg::ST_FLUSH && status.flush_ack) |=>
         (state_ff == hcbp_pkg::ST_IDLE && !(rsp_valid && $past(rsp_valid) && $past(rsp_stall)
          && !$stable(rsp_out_byte))))
   else $error("flush did not complete cleanly");

endmodule
